// File: src/md2kvl_pkg.sv
// Shared types, register indexes and the normal table of the keyframe vertex blender.
`timescale 1ns / 1ps
package md2kvl_pkg;

   localparam int NORMAL_TABLE_SIZE = 162;
   localparam int WEIGHT_W = 17;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_A_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_A_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_A_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_B_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_B_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_B_Z = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODEL_SCALE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIN_DIMS = 3'd7;

   typedef struct packed {
      logic [7:0] vertex_a_x;
      logic [7:0] vertex_a_y;
      logic [7:0] vertex_a_z;
      logic [7:0] vertex_b_x;
      logic [7:0] vertex_b_y;
      logic [7:0] vertex_b_z;
      logic [7:0] normal_a_index;
      logic [7:0] normal_b_index;
      logic signed [15:0] texel_s;
      logic signed [15:0] texel_t;
      logic [16:0] blend_weight;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_payload_type;

   // Unit normals in Q1.14
   localparam logic signed [15:0] NORMAL_TABLE [NORMAL_TABLE_SIZE][3] = '{
      '{-8614,0,13937},'{-7256,3913,14159},'{-4837,0,15654},'{-5063,8192,13255},
      '{-2662,4307,15582},'{0,0,16384},'{0,13937,8614},'{-2419,11740,11169},
      '{2419,11740,11169},'{0,8614,13937},'{5063,8192,13255},'{8614,0,13937},
      '{4837,0,15654},'{7256,3913,14159},'{2662,4307,15582},'{-11169,2419,11740},
      '{-13255,5063,8192},'{-9630,6969,11275},'{-13937,8614,0},'{-14159,7256,3913},
      '{-11740,11169,2419},'{-11275,9630,6969},'{-8192,13255,5063},'{-3913,14159,7256},
      '{-6969,11275,9630},'{-11740,11169,-2419},'{-8192,13255,-5063},'{-8614,13937,0},
      '{0,13937,-8614},'{-3913,14159,-7256},'{0,15654,-4837},'{-4307,15582,-2662},
      '{0,16384,0},'{0,15654,4837},'{-4307,15582,2662},'{3913,14159,7256},
      '{4307,15582,2662},'{8192,13255,5063},'{3913,14159,-7256},'{4307,15582,-2662},
      '{8192,13255,-5063},'{13937,8614,0},'{11740,11169,2419},'{11740,11169,-2419},
      '{8614,13937,0},'{6969,11275,9630},'{14159,7256,3913},'{11275,9630,6969},
      '{13255,5063,8192},'{11169,2419,11740},'{9630,6969,11275},'{15654,4837,0},
      '{16384,0,0},'{15582,2662,4307},'{13937,-8614,0},'{15654,-4837,0},
      '{14159,-7256,3913},'{15582,-2662,4307},'{13255,-5063,8192},'{11169,-2419,11740},
      '{13937,0,8614},'{14159,7256,-3913},'{13255,5063,-8192},'{15582,2662,-4307},
      '{8614,0,-13937},'{11169,2419,-11740},'{11169,-2419,-11740},'{13937,0,-8614},
      '{13255,-5063,-8192},'{14159,-7256,-3913},'{15582,-2662,-4307},'{2419,11740,-11169},
      '{5063,8192,-13255},'{6969,11275,-9630},'{7256,3913,-14159},'{9630,6969,-11275},
      '{11275,9630,-6969},'{-2419,11740,-11169},'{-5063,8192,-13255},'{0,8614,-13937},
      '{-8614,0,-13937},'{-7256,3913,-14159},'{-4837,0,-15654},'{-2662,4307,-15582},
      '{0,0,-16384},'{4837,0,-15654},'{2662,4307,-15582},'{-7256,-3913,-14159},
      '{-5063,-8192,-13255},'{-2662,-4307,-15582},'{0,-13937,-8614},'{-2419,-11740,-11169},
      '{2419,-11740,-11169},'{0,-8614,-13937},'{5063,-8192,-13255},'{7256,-3913,-14159},
      '{2662,-4307,-15582},'{3913,-14159,-7256},'{8192,-13255,-5063},'{6969,-11275,-9630},
      '{11740,-11169,-2419},'{11275,-9630,-6969},'{9630,-6969,-11275},'{0,-15654,-4837},
      '{0,-16384,0},'{4307,-15582,-2662},'{0,-13937,8614},'{0,-15654,4837},
      '{3913,-14159,7256},'{4307,-15582,2662},'{8192,-13255,5063},'{11740,-11169,2419},
      '{8614,-13937,0},'{-3913,-14159,-7256},'{-8192,-13255,-5063},'{-4307,-15582,-2662},
      '{-13937,-8614,0},'{-11740,-11169,-2419},'{-11740,-11169,2419},'{-8614,-13937,0},
      '{-8192,-13255,5063},'{-3913,-14159,7256},'{-4307,-15582,2662},'{-14159,-7256,3913},
      '{-13255,-5063,8192},'{-11275,-9630,6969},'{-11169,-2419,11740},'{-7256,-3913,14159},
      '{-9630,-6969,11275},'{-5063,-8192,13255},'{-2419,-11740,11169},'{-6969,-11275,9630},
      '{-2662,-4307,15582},'{7256,-3913,14159},'{2662,-4307,15582},'{5063,-8192,13255},
      '{2419,-11740,11169},'{0,-8614,13937},'{6969,-11275,9630},'{9630,-6969,11275},
      '{11275,-9630,6969},'{-15654,4837,0},'{-15582,2662,4307},'{-16384,0,0},
      '{-13937,0,8614},'{-15654,-4837,0},'{-15582,-2662,4307},'{-14159,7256,-3913},
      '{-15582,2662,-4307},'{-13255,5063,-8192},'{-14159,-7256,-3913},'{-15582,-2662,-4307},
      '{-13255,-5063,-8192},'{-11169,2419,-11740},'{-11169,-2419,-11740},'{-13937,0,-8614},
      '{-11275,9630,-6969},'{-9630,6969,-11275},'{-6969,11275,-9630},'{-6969,-11275,-9630},
      '{-9630,-6969,-11275},'{-11275,-9630,-6969}
   };

endpackage

// File: src/md2_keyframe_vertex_lerp_core.sv
// Top level of the keyframe vertex blender: registers, pipeline alignment, handshake.
`timescale 1ns / 1ps
// Keyframe vertex blender. Takes one word per clock and returns one word per clock
// unless the output stalls. The pipeline depth is set by the texture divider,
// which retires one quotient bit per stage; the position path (5 stages) and
// normal path (3 stages) are delay-matched to it. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// req_ready drops only while a finished word waits at rsp. Configuration (csr_)
// may be written only while the pipeline is empty; registers 6 and 7 use the low
// 32 bits of csr_wdata. A zero skin dimension saturates the matching coordinate.
module md2_keyframe_vertex_lerp_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  md2kvl_pkg::req_payload_type            req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output md2kvl_pkg::rsp_payload_type            rsp_payload,
   input  logic                                   csr_we,
   input  logic [md2kvl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [md2kvl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import md2kvl_pkg::*;

   localparam int LAT     = FRACTION_BITS + 19;
   localparam int POS_DLY = LAT - 5;
   localparam int NRM_DLY = LAT - 3;

   // configuration
   logic [63:0] map_ff [6];
   logic [31:0] model_scale_ff;
   logic [31:0] skin_dims_ff;

   logic [LAT-1:0]     vld_ff;
   logic               en;
   logic               accept;
   logic [WEIGHT_W-1:0] weight;

   logic signed [31:0] pos   [3];
   logic signed [15:0] nrm   [3];
   logic signed [31:0] tex_u, tex_v;
   logic [95:0]        pos_dly_ff [POS_DLY];
   logic [47:0]        nrm_dly_ff [NRM_DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            map_ff[k] <= 64'd65536;
         end
         model_scale_ff <= 32'd65536;
         skin_dims_ff   <= 32'd65537;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_A_X:   map_ff[0] <= csr_wdata;
            CSR_FRAME_A_Y:   map_ff[1] <= csr_wdata;
            CSR_FRAME_A_Z:   map_ff[2] <= csr_wdata;
            CSR_FRAME_B_X:   map_ff[3] <= csr_wdata;
            CSR_FRAME_B_Y:   map_ff[4] <= csr_wdata;
            CSR_FRAME_B_Z:   map_ff[5] <= csr_wdata;
            CSR_MODEL_SCALE: model_scale_ff <= csr_wdata[31:0];
            CSR_SKIN_DIMS:   skin_dims_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // single pipeline enable; the last stage is the output register
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;
   assign rsp_valid = vld_ff[LAT-1];

   // weights above one act as one
   assign weight = (req_payload.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                           : req_payload.blend_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   md2kvl_pos_lane #(.FRACTION_BITS(FRACTION_BITS)) u_pos_x (
      .clock(clock), .en(en), .map_a(map_ff[0]), .map_b(map_ff[3]),
      .byte_a(req_payload.vertex_a_x), .byte_b(req_payload.vertex_b_x),
      .weight(weight), .model_scale(model_scale_ff), .pos(pos[0]));

   md2kvl_pos_lane #(.FRACTION_BITS(FRACTION_BITS)) u_pos_y (
      .clock(clock), .en(en), .map_a(map_ff[1]), .map_b(map_ff[4]),
      .byte_a(req_payload.vertex_a_y), .byte_b(req_payload.vertex_b_y),
      .weight(weight), .model_scale(model_scale_ff), .pos(pos[1]));

   md2kvl_pos_lane #(.FRACTION_BITS(FRACTION_BITS)) u_pos_z (
      .clock(clock), .en(en), .map_a(map_ff[2]), .map_b(map_ff[5]),
      .byte_a(req_payload.vertex_a_z), .byte_b(req_payload.vertex_b_z),
      .weight(weight), .model_scale(model_scale_ff), .pos(pos[2]));

   md2kvl_nrm_blend u_nrm (
      .clock(clock), .en(en), .idx_a(req_payload.normal_a_index),
      .idx_b(req_payload.normal_b_index), .weight(weight), .nrm(nrm));

   md2kvl_tex_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_u (
      .clock(clock), .en(en), .texel(req_payload.texel_s),
      .dim(skin_dims_ff[31:16]), .quo(tex_u));

   md2kvl_tex_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_v (
      .clock(clock), .en(en), .texel(req_payload.texel_t),
      .dim(skin_dims_ff[15:0]), .quo(tex_v));

   // align the short paths with the divider
   always_ff @(posedge clock) begin
      if (en) begin
         pos_dly_ff[0] <= {pos[0], pos[1], pos[2]};
         for (int k = 1; k < POS_DLY; k++) begin
            pos_dly_ff[k] <= pos_dly_ff[k-1];
         end
         nrm_dly_ff[0] <= {nrm[0], nrm[1], nrm[2]};
         for (int k = 1; k < NRM_DLY; k++) begin
            nrm_dly_ff[k] <= nrm_dly_ff[k-1];
         end
      end
   end

   always_comb begin
      rsp_payload.tex_u    = tex_u;
      rsp_payload.tex_v    = tex_v;
      rsp_payload.normal_x = nrm_dly_ff[NRM_DLY-1][47:32];
      rsp_payload.normal_y = nrm_dly_ff[NRM_DLY-1][31:16];
      rsp_payload.normal_z = nrm_dly_ff[NRM_DLY-1][15:0];
      rsp_payload.pos_x    = pos_dly_ff[POS_DLY-1][95:64];
      rsp_payload.pos_y    = pos_dly_ff[POS_DLY-1][63:32];
      rsp_payload.pos_z    = pos_dly_ff[POS_DLY-1][31:0];
   end

`ifndef SYNTHESIS
   // a zero skin width must saturate tex_u
   a_zero_width_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && skin_dims_ff[31:16] == 16'd0) |->
         (rsp_payload.tex_u == 32'sh7FFF_FFFF || rsp_payload.tex_u == 32'sh8000_0000))
      else $error("tex_u not saturated for zero skin width");

   // blended normals stay inside the unit range
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.normal_x >= -16'sd16384 && rsp_payload.normal_x <= 16'sd16384
                  && rsp_payload.normal_y >= -16'sd16384 && rsp_payload.normal_y <= 16'sd16384
                  && rsp_payload.normal_z >= -16'sd16384 && rsp_payload.normal_z <= 16'sd16384))
      else $error("blended normal out of range");

   // a stalled pipeline holds every word in flight
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

// File: src/md2kvl_pos_lane.sv
// One axis of the position path: decompress, blend, model scale, round and saturate.
`timescale 1ns / 1ps
module md2kvl_pos_lane #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic [63:0]        map_a,
   input  logic [63:0]        map_b,
   input  logic [7:0]         byte_a,
   input  logic [7:0]         byte_b,
   input  logic [16:0]        weight,
   input  logic [31:0]        model_scale,
   output logic signed [31:0] pos
);
   import md2kvl_pkg::*;

   localparam int POS_W  = 42;            // decompressed position
   localparam int DIFF_W = POS_W + 1;
   localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
   localparam int MAG_W  = 41;
   localparam int FULL_W = 76;
   localparam logic [FULL_W-1:0] HALF = FULL_W'(1) << (FRACTION_BITS - 1);
   localparam logic [FULL_W-1:0] MAX_MAG = FULL_W'(64'h7FFF_FFFF);
   localparam logic [FULL_W-1:0] MIN_MAG = FULL_W'(64'h8000_0000);

   // stage 1
   logic signed [POS_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [WEIGHT_W-1:0]     w1_ff;
   // stage 2
   logic signed [POS_W-1:0]  pa2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   // stage 3
   logic                    neg3_ff, neg3_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [POS_W-1:0]  blend;
   // stage 4
   logic                    neg4_ff;
   logic [63:0]             lo_ff, lo_in;
   logic [MAG_W-1:0]        hi_ff, hi_in;
   // stage 5
   logic [FULL_W-1:0]       full, q;
   logic signed [31:0]      pos_ff, pos_in;
   logic signed [DIFF_W-1:0] diff;

   always_comb begin
      pa_in = POS_W'($signed(map_a[63:32])) * $signed(POS_W'({1'b0, byte_a}))
            + POS_W'($signed(map_a[31:0]));
      pb_in = POS_W'($signed(map_b[63:32])) * $signed(POS_W'({1'b0, byte_b}))
            + POS_W'($signed(map_b[31:0]));
   end

   always_comb begin
      diff    = DIFF_W'(pb_ff) - DIFF_W'(pa_ff);
      prod_in = PROD_W'(diff) * $signed(PROD_W'({1'b0, w1_ff}));
   end

   // floor((w*d + half) / 2^16) via arithmetic shift
   always_comb begin
      rnd     = (prod_ff + PROD_W'(32768)) >>> 16;
      blend   = pa2_ff + POS_W'(rnd);
      neg3_in = blend[POS_W-1];
      mag_in  = neg3_in ? MAG_W'(-blend) : MAG_W'(blend);
   end

   always_comb begin
      lo_in = 64'(mag_ff[31:0]) * 64'(model_scale);
      hi_in = MAG_W'(mag_ff[MAG_W-1:32]) * MAG_W'(model_scale);
   end

   always_comb begin
      full = (FULL_W'(hi_ff) << 32) + FULL_W'(lo_ff) + HALF;
      q    = full >> FRACTION_BITS;
      if (neg4_ff) begin
         pos_in = (q >= MIN_MAG) ? 32'sh8000_0000 : -$signed(q[31:0]);
      end else begin
         pos_in = (q > MAX_MAG) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         w1_ff   <= weight;
         pa2_ff  <= pa_ff;
         prod_ff <= prod_in;
         neg3_ff <= neg3_in;
         mag_ff  <= mag_in;
         neg4_ff <= neg3_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         pos_ff  <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// File: src/md2kvl_tex_div.sv
// Pipelined restoring divider for one texture coordinate, one quotient bit per stage.
`timescale 1ns / 1ps
module md2kvl_tex_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] texel,
   input  logic [15:0]        dim,
   output logic signed [31:0] quo
);
   import md2kvl_pkg::*;

   localparam int DW = 17 + FRACTION_BITS;

   logic [15:0]   rem_ff [DW+1];
   logic [DW-1:0] nq_ff  [DW+1];
   logic [15:0]   dim_ff [DW+1];
   logic          neg_ff [DW+1];
   logic          zero_ff[DW+1];

   logic [15:0]   mag;
   logic [63:0]   qx;
   logic signed [31:0] quo_ff, quo_in;

   always_comb begin
      mag = texel[15] ? 16'(-texel) : 16'(texel);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         nq_ff[0]   <= (DW'(mag) << FRACTION_BITS) + DW'(dim >> 1);
         dim_ff[0]  <= dim;
         neg_ff[0]  <= texel[15];
         zero_ff[0] <= (dim == 16'd0);
      end
   end

   for (genvar i = 0; i < DW; i++) begin : g_step
      logic [16:0] trial;
      logic        ge;
      always_comb begin
         trial = {rem_ff[i], nq_ff[i][DW-1]};
         ge    = (trial >= {1'b0, dim_ff[i]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= ge ? 16'(trial - {1'b0, dim_ff[i]}) : trial[15:0];
            nq_ff[i+1]   <= {nq_ff[i][DW-2:0], ge};
            dim_ff[i+1]  <= dim_ff[i];
            neg_ff[i+1]  <= neg_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   always_comb begin
      qx = 64'(nq_ff[DW]);
      if (zero_ff[DW]) begin
         quo_in = neg_ff[DW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff[DW]) begin
         quo_in = (qx >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(qx[31:0]);
      end else begin
         quo_in = (qx > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qx[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// File: src/md2kvl_nrm_blend.sv
// Normal table lookup for both frames and per-axis blend.
`timescale 1ns / 1ps
module md2kvl_nrm_blend (
   input  logic               clock,
   input  logic               en,
   input  logic [7:0]         idx_a,
   input  logic [7:0]         idx_b,
   input  logic [16:0]        weight,
   output logic signed [15:0] nrm [3]
);
   import md2kvl_pkg::*;

   localparam int PROD_W = 36;

   logic signed [15:0]       na_ff [3];
   logic signed [15:0]       nb_ff [3];
   logic signed [15:0]       na2_ff[3];
   logic [WEIGHT_W-1:0]      w_ff;
   logic signed [PROD_W-1:0] prod_ff[3];
   logic signed [PROD_W-1:0] prod_in[3];
   logic signed [15:0]       out_ff[3];
   logic signed [15:0]       out_in[3];
   logic signed [PROD_W-1:0] rnd[3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = (PROD_W'(nb_ff[k]) - PROD_W'(na_ff[k]))
                    * $signed(PROD_W'({1'b0, w_ff}));
         rnd[k]     = (prod_ff[k] + PROD_W'(32768)) >>> 16;
         out_in[k]  = na2_ff[k] + 16'(rnd[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= weight;
         for (int k = 0; k < 3; k++) begin
            // out-of-range index reads as the zero vector
            na_ff[k]   <= (idx_a < 8'(NORMAL_TABLE_SIZE)) ? NORMAL_TABLE[idx_a][k] : 16'sd0;
            nb_ff[k]   <= (idx_b < 8'(NORMAL_TABLE_SIZE)) ? NORMAL_TABLE[idx_b][k] : 16'sd0;
            na2_ff[k]  <= na_ff[k];
            prod_ff[k] <= prod_in[k];
            out_ff[k]  <= out_in[k];
         end
      end
   end

   assign nrm = out_ff;

endmodule

// File: sim/tb_md2_keyframe_vertex_lerp_core.sv
// Testbench for md2_keyframe_vertex_lerp_core: directed and random vertex words checked
// against a local predictor.
`timescale 1ns / 1ps
module tb_md2_keyframe_vertex_lerp_core;
   import md2kvl_pkg::*;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_CYCLES = 60;   // pipeline depth is 35 at 16 fraction bits
   localparam int  RANDOM_WORDS = 700;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_A_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register shadow used by the predictor
   logic [63:0] map_shadow [8];
   rsp_payload_type vertex_queue [$];
   int error_count = 0;
   int cycle_count = 0;

   always #2 clock = ~clock;

   md2_keyframe_vertex_lerp_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------- predictor
   // blend toward b: a + floor((w*(b-a) + half) / 2^16)
   function automatic longint lerp16(longint a, longint b, longint w);
      return a + ((w * (b - a) + 64'sd32768) >>> 16);
   endfunction

   function automatic logic [31:0] clamp_s32(bit neg, logic [127:0] mag);
      if (neg) begin
         if (mag > 128'h8000_0000) mag = 128'h8000_0000;
         return 32'(-mag);
      end
      if (mag > 128'h7FFF_FFFF) mag = 128'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   function automatic longint unpack_pos(logic [63:0] map, logic [7:0] b);
      longint sc, off;
      sc = longint'(signed'(map[63:32]));
      off = longint'(signed'(map[31:0]));
      return sc * longint'({56'd0, b}) + off;
   endfunction

   // position times model scale, rounded half away from zero, saturated
   function automatic logic [31:0] scale_position(longint p, logic [31:0] ms);
      bit neg;
      logic [127:0] mag;
      neg = p < 0;
      mag = neg ? 128'(-p) : 128'(p);
      mag = (mag * {96'd0, ms} + 128'd32768) >> 16;
      return clamp_s32(neg, mag);
   endfunction

   function automatic logic [31:0] texel_to_uv(logic signed [15:0] s, logic [15:0] dim);
      bit neg;
      longint mag;
      neg = s < 0;
      mag = neg ? -longint'(s) : longint'(s);
      if (dim == 0) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag = ((mag <<< 16) + longint'(dim / 2)) / longint'(dim);
      return clamp_s32(neg, 128'(mag));
   endfunction

   function automatic rsp_payload_type predict_vertex(req_payload_type rq);
      rsp_payload_type r;
      longint w, na, nb, pa, pb;
      logic [7:0] va [3];
      logic [7:0] vb [3];
      logic [15:0] nrm [3];
      logic [31:0] pos [3];
      w = (rq.blend_weight > WEIGHT_ONE) ? 65536 : longint'(rq.blend_weight);
      va = '{rq.vertex_a_x, rq.vertex_a_y, rq.vertex_a_z};
      vb = '{rq.vertex_b_x, rq.vertex_b_y, rq.vertex_b_z};
      for (int ax = 0; ax < 3; ax++) begin
         // out-of-range normal index reads as the zero vector but still blends
         na = (rq.normal_a_index < NORMAL_TABLE_SIZE) ?
              longint'(NORMAL_TABLE[rq.normal_a_index][ax]) : 0;
         nb = (rq.normal_b_index < NORMAL_TABLE_SIZE) ?
              longint'(NORMAL_TABLE[rq.normal_b_index][ax]) : 0;
         nrm[ax] = 16'(lerp16(na, nb, w));
         pa = unpack_pos(map_shadow[ax], va[ax]);
         pb = unpack_pos(map_shadow[3 + ax], vb[ax]);
         pos[ax] = scale_position(lerp16(pa, pb, w), map_shadow[CSR_MODEL_SCALE][31:0]);
      end
      r.tex_u = texel_to_uv(rq.texel_s, map_shadow[CSR_SKIN_DIMS][31:16]);
      r.tex_v = texel_to_uv(rq.texel_t, map_shadow[CSR_SKIN_DIMS][15:0]);
      r.normal_x = nrm[0];
      r.normal_y = nrm[1];
      r.normal_z = nrm[2];
      r.pos_x = pos[0];
      r.pos_y = pos[1];
      r.pos_z = pos[2];
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertex_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_payload.tex_u, 32'h0);
         end else begin
            want = vertex_queue.pop_front();
            compare_field("tex_u", rsp_payload.tex_u, want.tex_u);
            compare_field("tex_v", rsp_payload.tex_v, want.tex_v);
            compare_field("normal_x", 32'(rsp_payload.normal_x), 32'(want.normal_x));
            compare_field("normal_y", 32'(rsp_payload.normal_y), 32'(want.normal_y));
            compare_field("normal_z", 32'(rsp_payload.normal_z), 32'(want.normal_z));
            compare_field("pos_x", rsp_payload.pos_x, want.pos_x);
            compare_field("pos_y", rsp_payload.pos_y, want.pos_y);
            compare_field("pos_z", rsp_payload.pos_z, want.pos_z);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------- receiver stalls
   // mode is redrawn periodically at random: always ready, coin flip, or long stalls
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (cycle_count % 50 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready = 1'b0;
            end else begin
               rsp_ready = 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- sender
   int burst_left = 0;

   // one vertex word; valid stays high for a following word in the same burst
   task automatic send_vertex(req_payload_type rq);
      @(negedge clock);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_payload = rq;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      vertex_queue = {vertex_queue, predict_vertex(rq)};
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (vertex_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_map(logic [CSR_INDEX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      map_shadow[idx] = (idx >= CSR_MODEL_SCALE) ? {32'd0, value[31:0]} : value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic req_payload_type random_vertex();
      req_payload_type rq;
      rq = req_payload_type'({$urandom, $urandom, $urandom, $urandom});
      // mostly legal normal indices and weights, sometimes out of range
      if ($urandom_range(0, 7) != 0) begin
         rq.normal_a_index = 8'($urandom_range(0, NORMAL_TABLE_SIZE - 1));
         rq.normal_b_index = 8'($urandom_range(0, NORMAL_TABLE_SIZE - 1));
      end
      case ($urandom_range(0, 9))
         0: rq.blend_weight = 17'd0;
         1: rq.blend_weight = WEIGHT_ONE;
         2, 3: ;  // keep full 17-bit value, above one half the time
         default: rq.blend_weight = 17'($urandom_range(0, 65536));
      endcase
      return rq;
   endfunction

   function automatic logic [63:0] random_map();
      logic [63:0] m;
      m = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: m[63:32] = 32'h7FFF_FFFF;
         1: m[63:32] = 32'h8000_0000;
         2: m[63:32] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: ;
      endcase
      return m;
   endfunction

   function automatic req_payload_type make_vertex(logic [7:0] a, logic [7:0] b,
         logic [7:0] na, logic [7:0] nb, logic [15:0] s, logic [15:0] t, logic [16:0] w);
      req_payload_type rq;
      rq = '{a, a, a, b, b, b, na, nb, s, t, w};
      return rq;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      send_vertex(make_vertex(8'd0, 8'd255, 8'd0, 8'd161, 16'd0, 16'd1, 17'd0));
      send_vertex(make_vertex(8'd255, 8'd0, 8'd5, 8'd84, 16'h7FFF, 16'h8000, WEIGHT_ONE));
      send_vertex(make_vertex(8'd17, 8'd200, 8'd32, 8'd104, 16'hFFFF, 16'd100, 17'd32768));
      settle_idle();
   endtask

   task automatic test_special_cases();
      // weight above one
      send_vertex(make_vertex(8'd10, 8'd250, 8'd52, 8'd143, 16'd5, 16'd6, 17'd65537));
      send_vertex(make_vertex(8'd10, 8'd250, 8'd52, 8'd143, 16'd5, 16'd6, 17'h1FFFF));
      // single frame: weight 0, both frames equal
      send_vertex(make_vertex(8'd99, 8'd99, 8'd70, 8'd70, 16'd40, 16'd80, 17'd0));
      // bad normal indices, still blended
      send_vertex(make_vertex(8'd1, 8'd2, 8'd162, 8'd10, 16'd1, 16'd1, 17'd16384));
      send_vertex(make_vertex(8'd1, 8'd2, 8'd7, 8'd255, 16'd1, 16'd1, 17'd49152));
      send_vertex(make_vertex(8'd1, 8'd2, 8'd255, 8'd162, 16'd1, 16'd1, 17'd1));
      settle_idle();
      // zero skin size on each axis, then position overflow
      write_map(CSR_SKIN_DIMS, 64'h0000_0000_0000_0040);
      send_vertex(make_vertex(8'd3, 8'd4, 8'd0, 8'd1, 16'd0, 16'd7, 17'd3));
      send_vertex(make_vertex(8'd3, 8'd4, 8'd0, 8'd1, 16'h8000, 16'hFFF0, 17'd3));
      settle_idle();
      write_map(CSR_SKIN_DIMS, 64'h0000_0000_0100_0000);
      send_vertex(make_vertex(8'd3, 8'd4, 8'd0, 8'd1, 16'h7FFF, 16'h8000, 17'd3));
      send_vertex(make_vertex(8'd3, 8'd4, 8'd0, 8'd1, 16'h8000, 16'd0, 17'd3));
      settle_idle();
      for (int i = 0; i < 3; i++) write_map(CSR_INDEX_W'(i), 64'h7FFF_FFFF_7FFF_FFFF);
      for (int i = 3; i < 6; i++) write_map(CSR_INDEX_W'(i), 64'h8000_0000_8000_0000);
      write_map(CSR_MODEL_SCALE, 64'hFFFF_FFFF);
      write_map(CSR_SKIN_DIMS, 64'hFFFF_FFFF);
      send_vertex(make_vertex(8'd255, 8'd255, 8'd0, 8'd0, 16'h7FFF, 16'h8000, 17'd0));
      send_vertex(make_vertex(8'd255, 8'd255, 8'd0, 8'd0, 16'h7FFF, 16'h8000, WEIGHT_ONE));
      send_vertex(make_vertex(8'd0, 8'd0, 8'd0, 8'd0, 16'h0001, 16'hFFFF, 17'd32768));
      settle_idle();
      write_map(CSR_MODEL_SCALE, 64'h0);
      send_vertex(make_vertex(8'd255, 8'd128, 8'd9, 8'd9, 16'd2, 16'd3, 17'd777));
      settle_idle();
   endtask

   task automatic test_random_settings();
      int per_phase;
      per_phase = RANDOM_WORDS / 7;
      for (int phase = 0; phase < 7; phase++) begin
         for (int i = 0; i < 6; i++) write_map(CSR_INDEX_W'(i), random_map());
         case (phase % 3)
            0: write_map(CSR_MODEL_SCALE, 64'h0001_0000);
            1: write_map(CSR_MODEL_SCALE, {32'd0, $urandom_range(0, 32'h0004_0000)});
            default: write_map(CSR_MODEL_SCALE, {32'd0, $urandom});
         endcase
         write_map(CSR_SKIN_DIMS, (phase == 3) ? 64'h0 : {32'd0, $urandom});
         for (int i = 0; i < per_phase; i++) send_vertex(random_vertex());
         settle_idle();
      end
   endtask

   initial begin
      map_shadow = '{64'd65536, 64'd65536, 64'd65536, 64'd65536, 64'd65536, 64'd65536,
                     64'd65536, 64'd65537};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_random_settings();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
